// File: hdl/assert_macros.svh
// Assertion macros used by the checker module.
// Both macros need clk visible where used; CDT_ASSERT also rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while reset is released.
`define CDT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, also during reset.
`define CDT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/cdt_pkg.sv
// ----------------------------------------------------------------------------
// Countdown timer package
// Field widths, stream packing, register map and time constants shared by
// the timer and its checker.
// ----------------------------------------------------------------------------
package cdt_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 48;
  localparam int CFG_ADDR_W  = 4;
  localparam int CFG_DATA_W  = 32;

  localparam int TOTAL_W = 24;
  localparam int HOUR_W  = 7;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int DAY_W   = 17;

  localparam logic [TOTAL_W-1:0] MAX_SECONDS   = 24'd9999999;
  localparam logic [TOTAL_W-1:0] SECS_PER_HOUR = 24'd3600;
  localparam logic [TOTAL_W-1:0] SECS_PER_MIN  = 24'd60;
  localparam logic [20:0]        SECS_PER_DAY  = 21'd86400;

  typedef enum logic [1:0] {
    REG_TIMER_MODE    = 2'd0,
    REG_START_SECONDS = 2'd1,
    REG_SET_HOURS     = 2'd2,
    REG_SET_MINUTES   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_SECONDS   = 2'd0,
    MODE_HOURS_MIN = 2'd1,
    MODE_TIME_DAY  = 2'd2,
    MODE_UNUSED    = 2'd3
  } timer_mode_t;

  typedef struct packed {
    logic               active;
    logic               expired;
    logic [TOTAL_W-1:0] total;
  } tick_t;

  function automatic logic [7:0] bcd_decode(input logic [7:0] bcd);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = {4'd0, bcd[7:4]};
    lo = {4'd0, bcd[3:0]};
    return (hi << 3) + (hi << 1) + lo;
  endfunction

endpackage

// File: hdl/countdown_timer_hms.sv
// ----------------------------------------------------------------------------
// Countdown timer with hours, minutes and seconds breakdown
// Once-per-second countdown in seconds, hours:minutes or to a time of day.
// ----------------------------------------------------------------------------
// Each request on the in_ stream is one tick of one second and produces
// exactly one result on the out_ stream, in order. A tick with start_req set
// loads the count from the registers and shows the loaded value at once.
// The user must write the registers through the cfg_ port only while the
// block is idle; the block itself does not enforce it. Mode 0 counts down
// start_seconds, mode 1 counts down set_hours and set_minutes, and mode 2
// counts down to that time of day using the BCD wall clock carried with
// each tick. The tick that shows zero raises expired and the timer goes
// idle; idle ticks return all zero fields. One request is taken every cycle
// while the receiver does not stall: a six-stage pipeline with a valid bit
// per stage. The timer state updates as a request enters the second stage,
// and the remaining stages split the total with constant reciprocal
// multiplies. When the receiver stalls, the result holds and the pipeline
// keeps filling its empty stages before in_tready falls. Reset clears the
// registers, the timer state and every valid bit.
module countdown_timer_hms (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // start_req, clock_hours_bcd, clock_minutes_bcd, clock_seconds_bcd
  input  logic [cdt_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // active, remaining_total, remaining_hours, remaining_minutes,
  // remaining_seconds, expired
  output logic [cdt_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [cdt_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [cdt_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [cdt_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);
  import cdt_pkg::*;

  timer_mode_t        timer_mode_r;
  logic [TOTAL_W-1:0] start_seconds_r;
  logic [HOUR_W-1:0]  set_hours_r;
  logic [HOUR_W-1:0]  set_minutes_r;
  cfg_reg_t           cfg_index;
  logic               cfg_write;

  logic [TOTAL_W-1:0] down_count_r, down_count_nxt;
  logic               running_r, running_nxt;
  logic [DAY_W-1:0]   target_r, target_nxt;

  logic               a_valid_r, b_valid_r, c_valid_r, d_valid_r, e_valid_r;
  logic               a_ready, b_ready, c_ready, d_ready, e_ready, f_ready;
  logic               a_start_r;
  logic [7:0]         a_hh_r, a_mm_r, a_ss_r;

  tick_t              b_tick_r, b_tick_nxt, c_tick_r, d_tick_r, e_tick_r, f_tick_r;
  logic [12:0]        c_qh0_r, d_qh_r, e_qh_r;
  logic [18:0]        c_qm0_r, d_qm_r;
  logic [SEC_W-1:0]   d_sec_r, e_sec_r, f_sec_r;
  logic [MIN_W-1:0]   e_min_r, f_min_r;
  logic [6:0]         e_qd0_r;
  logic [HOUR_W-1:0]  f_hour_r;
  logic               out_valid_r;

  logic [TOTAL_W-1:0] hm_len;
  logic               start_ok;
  logic [TOTAL_W-1:0] count_cur;
  logic [DAY_W-1:0]   target_cur;
  logic               running_cur;
  logic [20:0]        now_secs;
  logic signed [21:0] left_raw, left_adj;

  logic [39:0]        prod_h;
  logic [40:0]        prod_m;
  logic [TOTAL_W-1:0] rem_h, rem_m;
  logic [18:0]        min_full;
  logic [22:0]        prod_d;
  logic [12:0]        rem_d;

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_index  = cfg_reg_t'(cfg_paddr[3:2]);
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_index)
      REG_TIMER_MODE:    cfg_prdata = {30'd0, timer_mode_r};
      REG_START_SECONDS: cfg_prdata = {8'd0, start_seconds_r};
      REG_SET_HOURS:     cfg_prdata = {25'd0, set_hours_r};
      REG_SET_MINUTES:   cfg_prdata = {25'd0, set_minutes_r};
      default:           cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timer_mode_r    <= MODE_SECONDS;
      start_seconds_r <= '0;
      set_hours_r     <= '0;
      set_minutes_r   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TIMER_MODE:    timer_mode_r    <= timer_mode_t'(cfg_pwdata[1:0]);
        REG_START_SECONDS: start_seconds_r <= cfg_pwdata[TOTAL_W-1:0];
        REG_SET_HOURS:     set_hours_r     <= cfg_pwdata[HOUR_W-1:0];
        REG_SET_MINUTES:   set_minutes_r   <= cfg_pwdata[HOUR_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage handshakes.
  assign f_ready   = !out_valid_r || out_tready;
  assign e_ready   = !e_valid_r || f_ready;
  assign d_ready   = !d_valid_r || e_ready;
  assign c_ready   = !c_valid_r || d_ready;
  assign b_ready   = !b_valid_r || c_ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign in_tready = a_ready;

  // Timer state update for the request leaving stage A.
  always_comb begin
    hm_len = TOTAL_W'(set_hours_r) * SECS_PER_HOUR + TOTAL_W'(set_minutes_r) * SECS_PER_MIN;
    case (timer_mode_r)
      MODE_SECONDS:   start_ok = (start_seconds_r <= MAX_SECONDS);
      MODE_HOURS_MIN: start_ok = (set_hours_r <= 7'd99) && (set_minutes_r <= 7'd99);
      MODE_TIME_DAY:  start_ok = (set_hours_r <= 7'd23) && (set_minutes_r <= 7'd59);
      default:        start_ok = 1'b0;
    endcase

    count_cur   = down_count_r;
    target_cur  = target_r;
    running_cur = running_r;
    if (a_start_r && start_ok) begin
      running_cur = 1'b1;
      case (timer_mode_r)
        MODE_SECONDS:   count_cur  = start_seconds_r;
        MODE_HOURS_MIN: count_cur  = hm_len;
        MODE_TIME_DAY:  target_cur = hm_len[DAY_W-1:0];
        default: ;
      endcase
    end

    now_secs = 21'(bcd_decode(a_hh_r)) * 21'(SECS_PER_HOUR)
             + 21'(bcd_decode(a_mm_r)) * 21'(SECS_PER_MIN)
             + 21'(bcd_decode(a_ss_r));
    left_raw = $signed({5'd0, target_cur}) - $signed({1'b0, now_secs});
    left_adj = left_raw[21] ? left_raw + $signed({1'b0, SECS_PER_DAY}) : left_raw;

    down_count_nxt     = count_cur;
    target_nxt         = target_cur;
    running_nxt        = running_cur;
    b_tick_nxt.active  = running_cur;
    b_tick_nxt.expired = 1'b0;
    b_tick_nxt.total   = '0;
    if (running_cur) begin
      if (timer_mode_r == MODE_TIME_DAY) begin
        if (left_adj[21] || (left_adj == 22'sd0)) begin
          b_tick_nxt.expired = 1'b1;
        end else begin
          b_tick_nxt.total = TOTAL_W'(left_adj[20:0]);
        end
      end else begin
        b_tick_nxt.total = count_cur;
        if (count_cur == '0) begin
          b_tick_nxt.expired = 1'b1;
        end else begin
          down_count_nxt = count_cur - 1'b1;
        end
      end
      if (b_tick_nxt.expired) begin
        running_nxt = 1'b0;
      end
    end
  end

  // Breakdown of the total into hours, minutes and seconds.
  assign prod_h   = 40'(b_tick_r.total) * 40'd37282;
  assign prod_m   = 41'(b_tick_r.total) * 41'd69905;
  assign rem_h    = c_tick_r.total - TOTAL_W'(c_qh0_r) * SECS_PER_HOUR;
  assign rem_m    = c_tick_r.total - TOTAL_W'(c_qm0_r) * SECS_PER_MIN;
  assign min_full = d_qm_r - 19'(d_qh_r) * 19'd60;
  assign prod_d   = 23'(d_qh_r) * 23'd655;
  assign rem_d    = e_qh_r - 13'(e_qd0_r) * 13'd100;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r    <= 1'b0;
      b_valid_r    <= 1'b0;
      c_valid_r    <= 1'b0;
      d_valid_r    <= 1'b0;
      e_valid_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      down_count_r <= '0;
      running_r    <= 1'b0;
      target_r     <= '0;
    end else begin
      if (a_ready) a_valid_r <= in_tvalid;
      if (b_ready) b_valid_r <= a_valid_r;
      if (c_ready) c_valid_r <= b_valid_r;
      if (d_ready) d_valid_r <= c_valid_r;
      if (e_ready) e_valid_r <= d_valid_r;
      if (f_ready) out_valid_r <= e_valid_r;
      if (b_ready && a_valid_r) begin
        down_count_r <= down_count_nxt;
        running_r    <= running_nxt;
        target_r     <= target_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_start_r <= in_tdata[0];
      a_hh_r    <= in_tdata[8:1];
      a_mm_r    <= in_tdata[16:9];
      a_ss_r    <= in_tdata[24:17];
    end
    if (b_ready) begin
      b_tick_r <= b_tick_nxt;
    end
    if (c_ready) begin
      c_tick_r <= b_tick_r;
      c_qh0_r  <= prod_h[39:27];
      c_qm0_r  <= prod_m[40:22];
    end
    if (d_ready) begin
      d_tick_r <= c_tick_r;
      d_qh_r   <= (rem_h >= SECS_PER_HOUR) ? c_qh0_r + 1'b1 : c_qh0_r;
      if (rem_m >= SECS_PER_MIN) begin
        d_qm_r  <= c_qm0_r + 1'b1;
        d_sec_r <= SEC_W'(rem_m - SECS_PER_MIN);
      end else begin
        d_qm_r  <= c_qm0_r;
        d_sec_r <= rem_m[SEC_W-1:0];
      end
    end
    if (e_ready) begin
      e_tick_r <= d_tick_r;
      e_qh_r   <= d_qh_r;
      e_qd0_r  <= prod_d[22:16];
      e_min_r  <= min_full[MIN_W-1:0];
      e_sec_r  <= d_sec_r;
    end
    if (f_ready) begin
      f_tick_r <= e_tick_r;
      f_hour_r <= (rem_d >= 13'd100) ? HOUR_W'(rem_d - 13'd100) : rem_d[HOUR_W-1:0];
      f_min_r  <= e_min_r;
      f_sec_r  <= e_sec_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, f_tick_r.expired, f_sec_r, f_min_r, f_hour_r,
                       f_tick_r.total, f_tick_r.active};

endmodule

// File: hdl/cdt_checker.sv
// ----------------------------------------------------------------------------
// Countdown timer port checker
// Watches the result stream of the timer and checks its handshake and the
// consistency of the reported fields.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cdt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [cdt_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import cdt_pkg::*;

  logic               active;
  logic               expired;
  logic [TOTAL_W-1:0] total;
  logic [MIN_W-1:0]   minutes;
  logic [SEC_W-1:0]   seconds;

  assign active  = out_tdata[0];
  assign total   = out_tdata[24:1];
  assign minutes = out_tdata[37:32];
  assign seconds = out_tdata[43:38];
  assign expired = out_tdata[44];

  `CDT_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_tvalid, "result valid after reset")
  `CDT_ASSERT(a_hold_stalled, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata),
    "stalled result changed")
  `CDT_ASSERT(a_expired_active, out_tvalid && expired |-> active && (total == '0),
    "expiry outside a running countdown or with time left")
  `CDT_ASSERT(a_idle_zero, out_tvalid && !active |-> (out_tdata == '0),
    "idle tick with nonzero fields")
  `CDT_ASSERT(a_field_range, out_tvalid |-> (minutes < 6'd60) && (seconds < 6'd60),
    "minutes or seconds out of range")

endmodule

bind countdown_timer_hms cdt_checker u_cdt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
